// File: design/spme_pkg.sv
// Shared constants, types and the controller state encoding of the shortest-path engine.
package spme_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int WEIGHT_BITS  = 16;
   localparam int VTX_BITS     = 5;
   localparam int CNT_BITS     = 6;
   localparam int DIST_BITS    = 22;
   localparam int EDGE_ADDR_BITS = 2 * VTX_BITS;
   localparam int EDGE_DEPTH   = MAX_VERTICES * MAX_VERTICES;

   localparam logic [DIST_BITS-1:0] DIST_INF  = '1;
   localparam logic [CNT_BITS-1:0]  PRED_NONE = '1;
   localparam logic [CNT_BITS-1:0]  VC_RESET  = 6'd32;
   localparam logic [CNT_BITS-1:0]  VC_MAX    = 6'd32;
   localparam logic                 KIND_EDGE = 1'b0;
   localparam logic                 KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                      en;
      logic [EDGE_ADDR_BITS-1:0] addr;
      logic [WEIGHT_BITS-1:0]    data;
   } edge_wr_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] cost;
      logic [CNT_BITS-1:0]  pred;
      logic                 done;
   } node_type;

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b00_0000_0001,
      S_IDLE     = 10'b00_0000_0010,
      S_INIT     = 10'b00_0000_0100,
      S_SEL      = 10'b00_0000_1000,
      S_RELAX    = 10'b00_0001_0000,
      S_WALK_RD  = 10'b00_0010_0000,
      S_WALK_CHK = 10'b00_0100_0000,
      S_EMIT_RD  = 10'b00_1000_0000,
      S_EMIT_OUT = 10'b01_0000_0000,
      S_NONE     = 10'b10_0000_0000
   } state_type;

endpackage

// File: design/spme_edge_store.sv
// Adjacency matrix memory with its clearing pass after reset.
module spme_edge_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spme_pkg::edge_wr_type                 wr,
   input  logic [spme_pkg::EDGE_ADDR_BITS-1:0]   raddr,
   output logic [spme_pkg::WEIGHT_BITS-1:0]      rdata,
   output logic                                  ready
);

   logic [spme_pkg::WEIGHT_BITS-1:0] mem [spme_pkg::EDGE_DEPTH];
   logic [spme_pkg::EDGE_ADDR_BITS:0] clr_ff, clr_in;
   logic [spme_pkg::WEIGHT_BITS-1:0]  rdata_ff;

   assign ready = clr_ff[spme_pkg::EDGE_ADDR_BITS];
   assign clr_in = ready ? clr_ff : clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!ready) begin
         mem[clr_ff[spme_pkg::EDGE_ADDR_BITS-1:0]] <= '0;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/shortest_path_matrix_engine.sv
// Top level of the shortest-path engine: controller, node table and path stack.
// Usage: an item is a transfer on the req_ channel (start high while busy is low).
// An edge item (req_kind 0) writes one weight into the adjacency matrix while busy
// stays low and gives no result; weight 0 removes the edge.
// A query item (req_kind 1) runs Dijkstra from req_start_vertex over the active
// vertex count n and then returns the path to req_end_vertex on the rsp_ channel,
// one vertex per rsp_valid strobe, start first, the final one with rsp_last set.
// When no path exists a single result with rsp_path_valid low and rsp_last high
// is returned. Results are strobes of one cycle; the receiver cannot stall them.
// A query first initializes all 32 node table entries, then runs n-1 rounds
// (a scan for the nearest vertex and, if one is found, a scan relaxing its edges,
// each paced by the one read port of the node memory), then walks the path back
// from the end vertex and emits one result per path vertex.
// The vertex count is written on the csr_ channel, which is always ready; it may
// change only while the block is idle. Its reset value is 32.
// After reset all 1024 entries of the adjacency matrix are cleared one entry a
// cycle, during which busy stays high.
module shortest_path_matrix_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [spme_pkg::VTX_BITS-1:0]       req_edge_from,
   input  logic [spme_pkg::VTX_BITS-1:0]       req_edge_to,
   input  logic [spme_pkg::WEIGHT_BITS-1:0]    req_edge_weight,
   input  logic [spme_pkg::VTX_BITS-1:0]       req_start_vertex,
   input  logic [spme_pkg::VTX_BITS-1:0]       req_end_vertex,
   output logic                                rsp_valid,
   output logic [spme_pkg::VTX_BITS-1:0]       rsp_path_vertex,
   output logic                                rsp_path_valid,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [spme_pkg::CNT_BITS-1:0]       csr_data
);

   spme_pkg::state_type state_ff, state_in;
   logic [spme_pkg::CNT_BITS-1:0] vc_ff, vc_in, n_ff, n_in, scan_ff, scan_in;
   logic [spme_pkg::CNT_BITS-1:0] round_ff, round_in, best_ff, best_in;
   logic [spme_pkg::CNT_BITS-1:0] depth_ff, depth_in;
   logic [spme_pkg::VTX_BITS-1:0] start_ff, start_in, end_ff, end_in;
   logic [spme_pkg::VTX_BITS-1:0] u_ff, u_in, cur_ff, cur_in, idx_ff, idx_in;
   logic [spme_pkg::DIST_BITS-1:0] low_ff, low_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_pv_ff, rsp_pv_in, rsp_last_ff, rsp_last_in;
   logic [spme_pkg::VTX_BITS-1:0] rsp_vtx_ff, rsp_vtx_in;

   spme_pkg::node_type node_mem [spme_pkg::MAX_VERTICES];
   spme_pkg::node_type node_rdata, node_wdata;
   logic [spme_pkg::VTX_BITS-1:0] node_raddr, node_waddr;
   logic node_we;

   logic [spme_pkg::VTX_BITS-1:0] stack_mem [spme_pkg::MAX_VERTICES];
   logic [spme_pkg::VTX_BITS-1:0] stack_rdata, stack_waddr, stack_raddr, stack_wdata;
   logic stack_we;

   spme_pkg::edge_wr_type edge_wr;
   logic [spme_pkg::EDGE_ADDR_BITS-1:0] edge_raddr;
   logic [spme_pkg::WEIGHT_BITS-1:0] edge_rdata;
   logic edge_ready;

   logic accept;
   logic [spme_pkg::CNT_BITS-1:0] n_clamp, vprev;
   logic [spme_pkg::DIST_BITS-1:0] cand;
   logic take;

   spme_edge_store u_edge_store (
      .clock (clock),
      .reset (reset),
      .wr    (edge_wr),
      .raddr (edge_raddr),
      .rdata (edge_rdata),
      .ready (edge_ready)
   );

   assign busy      = (state_ff != spme_pkg::S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign n_clamp   = (vc_ff > spme_pkg::VC_MAX) ? spme_pkg::VC_MAX : vc_ff;
   assign vprev     = scan_ff - 1'b1;
   assign cand      = low_ff + spme_pkg::DIST_BITS'(edge_rdata);
   assign take      = !node_rdata.done && (node_rdata.cost < low_ff);

   assign edge_wr.en   = accept && (req_kind == spme_pkg::KIND_EDGE);
   assign edge_wr.addr = {req_edge_from, req_edge_to};
   assign edge_wr.data = req_edge_weight;
   assign edge_raddr   = {u_ff, scan_ff[spme_pkg::VTX_BITS-1:0]};

   assign vc_in = (csr_valid && csr_ready) ? csr_data : vc_ff;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; scan_in = scan_ff; round_in = round_ff; best_in = best_ff;
      depth_in = depth_ff; start_in = start_ff; end_in = end_ff;
      u_in = u_ff; cur_in = cur_ff; idx_in = idx_ff; low_in = low_ff;
      rsp_valid_in = 1'b0; rsp_pv_in = 1'b0; rsp_last_in = 1'b0; rsp_vtx_in = '0;
      node_raddr = scan_ff[spme_pkg::VTX_BITS-1:0];
      node_we = 1'b0; node_waddr = vprev[spme_pkg::VTX_BITS-1:0]; node_wdata = node_rdata;
      stack_we = 1'b0; stack_waddr = depth_ff[spme_pkg::VTX_BITS-1:0];
      stack_wdata = cur_ff; stack_raddr = idx_ff;

      unique case (state_ff)
         spme_pkg::S_CLEAR: begin
            if (edge_ready) state_in = spme_pkg::S_IDLE;
         end
         spme_pkg::S_IDLE: begin
            if (accept && req_kind != spme_pkg::KIND_EDGE) begin
               n_in = n_clamp;
               start_in = req_start_vertex;
               end_in = req_end_vertex;
               scan_in = '0;
               if (spme_pkg::CNT_BITS'(req_start_vertex) >= n_clamp ||
                   spme_pkg::CNT_BITS'(req_end_vertex) >= n_clamp ||
                   req_start_vertex == req_end_vertex) begin
                  state_in = spme_pkg::S_NONE;
               end else begin
                  state_in = spme_pkg::S_INIT;
               end
            end
         end
         spme_pkg::S_INIT: begin
            node_we = 1'b1;
            node_waddr = scan_ff[spme_pkg::VTX_BITS-1:0];
            node_wdata.cost = (scan_ff[spme_pkg::VTX_BITS-1:0] == start_ff) ?
                              '0 : spme_pkg::DIST_INF;
            node_wdata.pred = spme_pkg::PRED_NONE;
            node_wdata.done = 1'b0;
            if (scan_ff == spme_pkg::CNT_BITS'(spme_pkg::MAX_VERTICES - 1)) begin
               state_in = spme_pkg::S_SEL;
               scan_in = '0;
               round_in = '0;
               best_in = spme_pkg::PRED_NONE;
               low_in = spme_pkg::DIST_INF;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         spme_pkg::S_SEL: begin
            if (scan_ff != '0 && take) begin
               best_in = vprev;
               low_in = node_rdata.cost;
            end
            if (scan_ff == n_ff) begin
               scan_in = '0;
               if (best_in == spme_pkg::PRED_NONE) begin
                  round_in = round_ff + 1'b1;
                  best_in = spme_pkg::PRED_NONE;
                  low_in = spme_pkg::DIST_INF;
                  if (round_ff + 1'b1 == n_ff - 1'b1) begin
                     state_in = spme_pkg::S_WALK_RD;
                     cur_in = end_ff;
                     depth_in = '0;
                  end
               end else begin
                  u_in = best_in[spme_pkg::VTX_BITS-1:0];
                  state_in = spme_pkg::S_RELAX;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         spme_pkg::S_RELAX: begin
            if (scan_ff != '0) begin
               // The selected vertex is marked done on its own pass of the scan.
               if (vprev[spme_pkg::VTX_BITS-1:0] == u_ff) begin
                  node_we = 1'b1;
                  node_wdata.done = 1'b1;
               end else if (!node_rdata.done && edge_rdata != '0 &&
                            cand < node_rdata.cost) begin
                  node_we = 1'b1;
                  node_wdata.cost = cand;
                  node_wdata.pred = spme_pkg::CNT_BITS'(u_ff);
               end
            end
            if (scan_ff == n_ff) begin
               scan_in = '0;
               round_in = round_ff + 1'b1;
               best_in = spme_pkg::PRED_NONE;
               low_in = spme_pkg::DIST_INF;
               if (round_ff + 1'b1 == n_ff - 1'b1) begin
                  state_in = spme_pkg::S_WALK_RD;
                  cur_in = end_ff;
                  depth_in = '0;
               end else begin
                  state_in = spme_pkg::S_SEL;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         spme_pkg::S_WALK_RD: begin
            node_raddr = cur_ff;
            state_in = spme_pkg::S_WALK_CHK;
         end
         spme_pkg::S_WALK_CHK: begin
            if (depth_ff == '0 && node_rdata.pred == spme_pkg::PRED_NONE) begin
               state_in = spme_pkg::S_NONE;
            end else if (depth_ff < n_ff && node_rdata.pred != spme_pkg::PRED_NONE) begin
               stack_we = 1'b1;
               depth_in = depth_ff + 1'b1;
               if (node_rdata.pred[spme_pkg::CNT_BITS-1]) begin
                  state_in = spme_pkg::S_EMIT_RD;
                  idx_in = depth_ff[spme_pkg::VTX_BITS-1:0];
               end else begin
                  cur_in = node_rdata.pred[spme_pkg::VTX_BITS-1:0];
                  state_in = spme_pkg::S_WALK_RD;
               end
            end else begin
               state_in = spme_pkg::S_EMIT_RD;
               if (depth_ff < spme_pkg::CNT_BITS'(spme_pkg::MAX_VERTICES)) begin
                  stack_we = 1'b1;
                  depth_in = depth_ff + 1'b1;
                  idx_in = depth_ff[spme_pkg::VTX_BITS-1:0];
               end else begin
                  idx_in = spme_pkg::VTX_BITS'(depth_ff - 1'b1);
               end
            end
         end
         spme_pkg::S_EMIT_RD: begin
            state_in = spme_pkg::S_EMIT_OUT;
         end
         spme_pkg::S_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_pv_in = 1'b1;
            rsp_vtx_in = stack_rdata;
            rsp_last_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = spme_pkg::S_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
               state_in = spme_pkg::S_EMIT_RD;
            end
         end
         spme_pkg::S_NONE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in = 1'b1;
            state_in = spme_pkg::S_IDLE;
         end
         default: begin
            state_in = spme_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spme_pkg::S_CLEAR;
         vc_ff <= spme_pkg::VC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vc_ff <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; scan_ff <= scan_in; round_ff <= round_in; best_ff <= best_in;
      depth_ff <= depth_in; start_ff <= start_in; end_ff <= end_in;
      u_ff <= u_in; cur_ff <= cur_in; idx_ff <= idx_in; low_ff <= low_in;
      rsp_pv_ff <= rsp_pv_in; rsp_last_ff <= rsp_last_in; rsp_vtx_ff <= rsp_vtx_in;
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_waddr] <= node_wdata;
      node_rdata <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
      stack_rdata <= stack_mem[stack_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_vertex = rsp_vtx_ff;
   assign rsp_path_valid  = rsp_pv_ff;
   assign rsp_last        = rsp_last_ff;

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == spme_pkg::S_CLEAR |=> !rsp_valid)
      else $error("result during matrix clearing");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_path_valid |-> rsp_last)
      else $error("no-path result not flagged last");

   a_relax_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == spme_pkg::S_RELAX |-> spme_pkg::CNT_BITS'(u_ff) < n_ff)
      else $error("relaxing a vertex outside the active range");

   a_emit_in_stack: assert property (@(posedge clock) disable iff (reset)
      state_ff == spme_pkg::S_EMIT_OUT |-> spme_pkg::CNT_BITS'(idx_ff) < depth_ff)
      else $error("emitting beyond the path stack");

endmodule

// File: tb/tb.sv
// Testbench for the shortest-path matrix engine: directed and random edge and path checks.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [spme_pkg::VTX_BITS-1:0] vertex;
      logic                          valid;
      logic                          last;
   } hop_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = spme_pkg::KIND_EDGE;
   logic [spme_pkg::VTX_BITS-1:0] req_edge_from = '0;
   logic [spme_pkg::VTX_BITS-1:0] req_edge_to = '0;
   logic [spme_pkg::WEIGHT_BITS-1:0] req_edge_weight = '0;
   logic [spme_pkg::VTX_BITS-1:0] req_start_vertex = '0;
   logic [spme_pkg::VTX_BITS-1:0] req_end_vertex = '0;
   logic rsp_valid;
   logic [spme_pkg::VTX_BITS-1:0] rsp_path_vertex;
   logic rsp_path_valid;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [spme_pkg::CNT_BITS-1:0] csr_data = '0;

   // Predictor copy of the matrix and the vertex count.
   logic [spme_pkg::WEIGHT_BITS-1:0] adj_weight [spme_pkg::MAX_VERTICES][spme_pkg::MAX_VERTICES];
   logic [spme_pkg::CNT_BITS-1:0] active_count;
   hop_type path_queue[$];
   int failures = 0;
   int stall_cycles = 0;
   int sender_idle_pct = 0;

   shortest_path_matrix_engine uut (.*);

   always #2 clock = ~clock;

   function automatic void push_no_path();
      hop_type h;
      h.vertex = '0;
      h.valid = 1'b0;
      h.last = 1'b1;
      path_queue.push_back(h);
   endfunction

   // Dijkstra over the active vertices, then the path from start to end.
   function automatic void predict_path(int src, int dst);
      longint cost [spme_pkg::MAX_VERTICES];
      int pred [spme_pkg::MAX_VERTICES];
      bit visited [spme_pkg::MAX_VERTICES];
      int chain [$];
      int n, u, cur;
      longint low, cand;
      hop_type h;
      n = (active_count > spme_pkg::MAX_VERTICES) ? spme_pkg::MAX_VERTICES :
          int'(active_count);
      for (int i = 0; i < spme_pkg::MAX_VERTICES; i++) begin
         cost[i] = -1;
         pred[i] = -1;
         visited[i] = 0;
      end
      if (src >= n || dst >= n || src == dst) begin
         push_no_path();
         return;
      end
      cost[src] = 0;
      for (int r = 0; r + 1 < n; r++) begin
         u = -1;
         low = -1;
         for (int v = 0; v < n; v++)
            if (!visited[v] && cost[v] >= 0 && (low < 0 || cost[v] < low)) begin
               low = cost[v];
               u = v;
            end
         if (u >= 0) begin
            visited[u] = 1;
            for (int v = 0; v < n; v++)
               if (!visited[v] && adj_weight[u][v] != 0) begin
                  cand = cost[u] + longint'(adj_weight[u][v]);
                  if (cost[v] < 0 || cand < cost[v]) begin
                     cost[v] = cand;
                     pred[v] = u;
                  end
               end
         end
      end
      if (pred[dst] < 0) begin
         push_no_path();
         return;
      end
      cur = dst;
      while (pred[cur] >= 0) begin
         chain.push_front(cur);
         cur = pred[cur];
      end
      chain.push_front(cur);
      foreach (chain[k]) begin
         h.vertex = chain[k][spme_pkg::VTX_BITS-1:0];
         h.valid = 1'b1;
         h.last = (k == chain.size() - 1);
         path_queue.push_back(h);
      end
   endfunction

   // Sends one item; start stays high afterwards unless the next call idles.
   task automatic send_item(logic kind, int from, int to, int weight, int src, int dst);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_kind = kind;
      req_edge_from = from[spme_pkg::VTX_BITS-1:0];
      req_edge_to = to[spme_pkg::VTX_BITS-1:0];
      req_edge_weight = weight[spme_pkg::WEIGHT_BITS-1:0];
      req_start_vertex = src[spme_pkg::VTX_BITS-1:0];
      req_end_vertex = dst[spme_pkg::VTX_BITS-1:0];
      start = 1'b1;
      do @(posedge clock); while (busy);
      if (kind == spme_pkg::KIND_EDGE)
         adj_weight[from[spme_pkg::VTX_BITS-1:0]][to[spme_pkg::VTX_BITS-1:0]] =
            weight[spme_pkg::WEIGHT_BITS-1:0];
      else
         predict_path(src[spme_pkg::VTX_BITS-1:0], dst[spme_pkg::VTX_BITS-1:0]);
   endtask

   task automatic add_edge(int from, int to, int weight);
      send_item(spme_pkg::KIND_EDGE, from, to, weight, $urandom_range(31), $urandom_range(31));
   endtask

   task automatic ask_path(int src, int dst);
      send_item(spme_pkg::KIND_QUERY, $urandom_range(31), $urandom_range(31), $urandom,
                src, dst);
   endtask

   // Waits until the block is quiet, then writes the vertex count.
   task automatic set_vertex_count(int value);
      @(negedge clock);
      start = 1'b0;
      wait (path_queue.size() == 0);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      csr_data = value[spme_pkg::CNT_BITS-1:0];
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      active_count = value[spme_pkg::CNT_BITS-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_basic_paths();
      add_edge(0, 31, 65535);
      add_edge(0, 1, 1);
      add_edge(1, 31, 1);
      ask_path(0, 31);
      ask_path(31, 0);
      ask_path(5, 5);
      add_edge(1, 31, 0);
      ask_path(0, 31);
      // Two routes of equal length to vertex 3; the first one found is kept.
      add_edge(2, 3, 2);
      add_edge(2, 4, 1);
      add_edge(4, 3, 1);
      ask_path(2, 3);
      add_edge(31, 30, 65535);
      add_edge(30, 0, 65535);
      ask_path(31, 1);
   endtask

   task automatic test_vertex_counts();
      set_vertex_count(4);
      ask_path(2, 3);
      ask_path(0, 31);
      ask_path(5, 1);
      set_vertex_count(0);
      ask_path(0, 1);
      set_vertex_count(1);
      ask_path(0, 0);
      set_vertex_count(63);
      ask_path(31, 1);
      set_vertex_count(33);
      ask_path(2, 3);
      set_vertex_count(2);
      ask_path(0, 1);
   endtask

   task automatic test_random_graphs(int epochs);
      int n, pick;
      for (int e = 0; e < epochs; e++) begin
         pick = $urandom_range(9);
         n = (pick == 0) ? 32 : (pick == 1) ? $urandom_range(9, 16) : $urandom_range(2, 8);
         set_vertex_count(n);
         repeat (35) begin
            pick = $urandom_range(99);
            if (pick < 60)
               add_edge($urandom_range(n - 1), $urandom_range(n - 1),
                        ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 20));
            else if (pick < 68)
               add_edge($urandom_range(31), $urandom_range(31),
                        ($urandom_range(1) == 0) ? 0 : $urandom);
            else if (pick < 94)
               ask_path($urandom_range(n - 1), $urandom_range(n - 1));
            else
               ask_path($urandom_range(31), $urandom_range(31));
         end
      end
   endtask

   always @(posedge clock) begin
      hop_type h;
      if ((start && !busy) || rsp_valid || csr_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (path_queue.size() == 0) begin
            $error("unexpected result: vertex %0d valid %0b last %0b",
                   rsp_path_vertex, rsp_path_valid, rsp_last);
            failures++;
         end else begin
            h = path_queue.pop_front();
            if (rsp_path_vertex !== h.vertex) begin
               $error("path_vertex: expected %0d, got %0d", h.vertex, rsp_path_vertex);
               failures++;
            end
            if (rsp_path_valid !== h.valid) begin
               $error("path_valid: expected %0b, got %0b", h.valid, rsp_path_valid);
               failures++;
            end
            if (rsp_last !== h.last) begin
               $error("last: expected %0b, got %0b", h.last, rsp_last);
               failures++;
            end
         end
      end
   end

   initial begin
      foreach (adj_weight[i, j]) adj_weight[i][j] = '0;
      active_count = spme_pkg::VC_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      sender_idle_pct = 11;
      test_basic_paths();
      test_vertex_counts();
      test_random_graphs(4);
      sender_idle_pct = 83;
      test_random_graphs(4);
      sender_idle_pct = 0;
      test_random_graphs(4);
      @(negedge clock);
      start = 1'b0;
      wait (path_queue.size() == 0);
      repeat (50) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// File: files.f
design/spme_pkg.sv
design/spme_edge_store.sv
design/shortest_path_matrix_engine.sv
tb/tb.sv
